// ===== rtl/lzss_pkg.sv =====
// Package for the LZSS stream decompressor: parse phases, status codes,
// controller state and command/status structs. No dependencies.
`default_nettype none
package lzss_pkg;
   localparam int WindowDepthDefault = 8192;
   localparam int BytesPerResultDefault = 8;
   localparam int PosWidth = 24;
   localparam int LongBase = 8192;
   localparam int ShortBase = 256;

   typedef enum logic [3:0] {
      PH_TYPE, PH_KIND, PH_SHORT_HI, PH_SHORT_LO, PH_LITERAL,
      PH_LONG_LO, PH_LONG_HI, PH_LONG_EXT, PH_SHORT_DIST
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUNNING = 3'd0, ST_END_MARK = 3'd1, ST_FULL = 3'd2,
      ST_BAD_DIST = 3'd3, ST_TRUNC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_BITS, CS_BYTE, CS_COPY_RD, CS_COPY_WR, CS_FINISH, CS_EMIT
   } ctrl_state_type;

   localparam logic [0:0] CSR_OUTPUT_SIZE = 1'b0;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch input beat
      logic bit_step;     // consume one flag bit
      logic byte_step;    // process captured byte
      logic copy_rd;      // issue history read
      logic copy_wr;      // write copied byte
      logic finish_chk;   // final status checks
      logic emit;         // load result register with pack
      logic emit_empty;   // emit status-only beat
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic finished;
      logic can_bit;      // a flag bit is available in a bit phase
      logic bit_phase;
      logic copy_more;    // copy bytes remain
      logic pack_full;
      logic pack_any;
      logic status_set;
      logic out_busy;     // result register still occupied
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/lzss_if.sv =====
// Valid/ready stream interfaces for the decompressor channels.
// Depends on nothing; payload widths are fixed or parameterized.
`default_nettype none
interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source(output valid, in_byte, in_last, input ready);
   modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface lzss_rsp_if #(parameter int BYTES_PER_RESULT = 8);
   logic                          valid;
   logic                          ready;
   logic [8*BYTES_PER_RESULT-1:0] out_data;
   logic [3:0]                    out_count;
   logic                          run_last;
   logic [2:0]                    status;
   logic [23:0]                   bytes_done;
   modport source(output valid, out_data, out_count, run_last, status, bytes_done,
                  input ready);
   modport sink(input valid, out_data, out_count, run_last, status, bytes_done,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/lzss_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/lzss_ctrl.sv =====
// Controller state machine of the decompressor.
// Depends on lzss_pkg.
`default_nettype none
module lzss_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lzss_pkg::sts_type       sts,
   output lzss_pkg::cmd_type            cmd
);
   import lzss_pkg::*;
   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               // a finished run drops the beat
               if (!sts.finished) state_in = CS_BITS;
            end
         end
         CS_BITS: begin
            if (sts.bit_phase && sts.can_bit) cmd.bit_step = 1'b1;
            else state_in = CS_BYTE;
         end
         CS_BYTE: begin
            cmd.byte_step = 1'b1;
            state_in = CS_COPY_RD;
         end
         CS_COPY_RD: begin
            if (sts.copy_more) begin
               // hand over a full pack before the next byte
               if (sts.pack_full) begin
                  if (!sts.out_busy) cmd.emit = 1'b1;
               end else begin
                  cmd.copy_rd = 1'b1;
                  state_in = CS_COPY_WR;
               end
            end else state_in = CS_FINISH;
         end
         CS_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            state_in = CS_COPY_RD;
         end
         CS_FINISH: begin
            cmd.finish_chk = 1'b1;
            state_in = CS_EMIT;
         end
         CS_EMIT: begin
            if (!sts.pack_any && !sts.status_set) state_in = CS_IDLE;
            else if (!sts.out_busy) begin
               if (sts.pack_any) cmd.emit = 1'b1;
               else cmd.emit_empty = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/lzss_dpath.sv =====
// Datapath of the decompressor: flag parser, match copier, history RAM,
// output packer and result register. Depends on lzss_pkg and lzss_ram.
`default_nettype none
module lzss_dpath #(
   parameter int WINDOW_DEPTH = lzss_pkg::WindowDepthDefault,
   parameter int BYTES_PER_RESULT = lzss_pkg::BytesPerResultDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    req_in_byte,
   input  wire logic                          req_in_last,
   input  wire logic [23:0]                   output_size,
   input  wire lzss_pkg::cmd_type             cmd,
   output lzss_pkg::sts_type                  sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [8*BYTES_PER_RESULT-1:0]      rsp_out_data,
   output logic [3:0]                         rsp_out_count,
   output logic                               rsp_run_last,
   output logic [2:0]                         rsp_status,
   output logic [23:0]                        rsp_bytes_done
);
   import lzss_pkg::*;
   localparam int AddrWidth = $clog2(WINDOW_DEPTH);
   localparam int CntWidth = $clog2(BYTES_PER_RESULT + 1);
   localparam int IdxWidth = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [23:0] pos_ff;
   logic [31:0] flag_ff;
   logic        loaded_ff;
   logic [31:0] gather_ff;
   logic [1:0]  gcnt_ff;
   phase_type   phase_ff;
   logic [15:0] match_ff;
   logic [1:0]  slen_ff;
   logic        fin_ff;
   status_type  stat_ff;
   logic [15:0] dist_ff;
   logic [8:0]  len_ff;
   logic [7:0]  pack_ff [BYTES_PER_RESULT];
   logic [CntWidth-1:0] pcnt_ff;
   logic        full_early_ff;   // output already full on arrival
   logic        fin_stage_ff;    // set once the final checks ran

   logic        ov_ff;
   logic [8*BYTES_PER_RESULT-1:0] od_ff;
   logic [3:0]  oc_ff;
   logic        ol_ff;
   logic [2:0]  os_ff;
   logic [23:0] ob_ff;

   logic [7:0]  rd_data;
   logic        bit_ph;
   logic        bitv;
   phase_type   ph_next;
   logic [1:0]  slen_next;

   logic [12:0] dfield;
   logic [15:0] hdist;
   logic [15:0] ldist;
   logic [15:0] sdist;
   logic [23:0] room;
   logic [8:0]  len_req;
   logic [8:0]  len_cut;
   logic [15:0] word_now;
   logic        emit_last;
   logic [8*BYTES_PER_RESULT-1:0] data_pack;

   assign bit_ph = (phase_ff == PH_TYPE) || (phase_ff == PH_KIND) ||
                   (phase_ff == PH_SHORT_HI) || (phase_ff == PH_SHORT_LO);

   // next phase for a given flag bit
   function automatic phase_type apply_ph(phase_type p, logic b);
      unique case (p)
         PH_KIND:     apply_ph = b ? PH_LONG_LO : PH_SHORT_HI;
         PH_SHORT_HI: apply_ph = PH_SHORT_LO;
         PH_SHORT_LO: apply_ph = PH_SHORT_DIST;
         default:     apply_ph = b ? PH_LITERAL : PH_KIND;
      endcase
   endfunction

   assign bitv = flag_ff[31];
   always_comb begin
      slen_next = slen_ff;
      if (phase_ff == PH_SHORT_HI) slen_next = {bitv, 1'b0};
      else if (phase_ff == PH_SHORT_LO) slen_next = {slen_ff[1], bitv};
      ph_next = apply_ph(phase_ff, bitv);
   end

   lzss_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
      .clock(clock),
      .wr_en(cmd.copy_wr || (cmd.byte_step && !full_early_ff && phase_ff == PH_LITERAL)),
      .wr_addr(pos_ff[AddrWidth-1:0]),
      .wr_data(cmd.copy_wr ? rd_data : byte_ff),
      .rd_addr(AddrWidth'(pos_ff - 24'(dist_ff))),
      .rd_data(rd_data)
   );

   assign word_now = {byte_ff, match_ff[7:0]};
   assign dfield = word_now[15:3];
   assign hdist = 16'(LongBase) - 16'(dfield);
   assign ldist = 16'(LongBase) - 16'(match_ff[15:3]);
   assign sdist = 16'(ShortBase) - 16'(byte_ff);
   assign room = (output_size > pos_ff) ? output_size - pos_ff : 24'd0;

   always_comb begin
      unique case (phase_ff)
         PH_LONG_HI:  len_req = 9'(word_now[2:0]) + 9'd2;
         PH_LONG_EXT: len_req = 9'(byte_ff) + 9'd2;
         default:     len_req = 9'(slen_ff) + 9'd2;
      endcase
   end
   // cut the copy at the wanted size
   assign len_cut = (24'(len_req) > room) ? 9'(room) : len_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; flag_ff <= '0; loaded_ff <= 1'b0; gather_ff <= '0;
         gcnt_ff <= '0; phase_ff <= PH_TYPE; match_ff <= '0; slen_ff <= '0;
         fin_ff <= 1'b0; stat_ff <= ST_RUNNING; len_ff <= '0; pcnt_ff <= '0;
         full_early_ff <= 1'b0; ov_ff <= 1'b0; dist_ff <= '0;
      end else begin
         if (cmd.capture) begin
            byte_ff <= req_in_byte;
            last_ff <= req_in_last;
            len_ff <= '0;
            full_early_ff <= !fin_ff && (pos_ff >= output_size);
            if (!fin_ff && pos_ff >= output_size) begin
               fin_ff <= 1'b1;
               stat_ff <= ST_FULL;
            end else stat_ff <= ST_RUNNING;
         end
         if (cmd.bit_step && !full_early_ff) begin
            flag_ff <= flag_ff << 1;
            phase_ff <= ph_next;
            slen_ff <= slen_next;
         end
         if (cmd.byte_step && !full_early_ff) begin
            if (bit_ph) begin
               if (gcnt_ff == 2'd3) begin
                  // word complete: apply the top flag bit, shift in the sentinel behind the other 31
                  flag_ff <= {byte_ff[6:0], gather_ff[23:0], 1'b1};
                  loaded_ff <= 1'b1;
                  phase_ff <= apply_ph(phase_ff, byte_ff[7]);
                  if (phase_ff == PH_SHORT_HI) slen_ff <= {byte_ff[7], 1'b0};
                  else if (phase_ff == PH_SHORT_LO) slen_ff <= {slen_ff[1], byte_ff[7]};
                  gather_ff <= '0;
                  gcnt_ff <= '0;
               end else begin
                  gather_ff <= gather_ff | (32'(byte_ff) << {gcnt_ff, 3'b000});
                  gcnt_ff <= gcnt_ff + 2'd1;
               end
            end else begin
               unique case (phase_ff)
                  PH_LITERAL: begin
                     pos_ff <= pos_ff + 24'd1;
                     pack_ff[0] <= byte_ff;
                     pcnt_ff <= CntWidth'(1);
                     phase_ff <= PH_TYPE;
                  end
                  PH_LONG_LO: begin
                     match_ff <= {8'd0, byte_ff};
                     phase_ff <= PH_LONG_HI;
                  end
                  PH_LONG_HI: begin
                     match_ff <= word_now;
                     if (word_now[2:0] != 3'd0) begin
                        phase_ff <= PH_TYPE;
                        if (24'(hdist) > pos_ff) begin
                           fin_ff <= 1'b1; stat_ff <= ST_BAD_DIST;
                        end else begin
                           dist_ff <= hdist;
                           len_ff <= len_cut;
                        end
                     end else phase_ff <= PH_LONG_EXT;
                  end
                  PH_LONG_EXT: begin
                     phase_ff <= PH_TYPE;
                     if (byte_ff == 8'd0) begin
                        fin_ff <= 1'b1; stat_ff <= ST_END_MARK;
                     end else if (24'(ldist) > pos_ff) begin
                        fin_ff <= 1'b1; stat_ff <= ST_BAD_DIST;
                     end else begin
                        dist_ff <= ldist;
                        len_ff <= len_cut;
                     end
                  end
                  default: begin
                     phase_ff <= PH_TYPE;
                     if (24'(sdist) > pos_ff) begin
                        fin_ff <= 1'b1; stat_ff <= ST_BAD_DIST;
                     end else begin
                        dist_ff <= sdist;
                        len_ff <= len_cut;
                     end
                  end
               endcase
            end
         end
         if (cmd.copy_wr) begin
            pack_ff[pcnt_ff[IdxWidth-1:0]] <= rd_data;
            pcnt_ff <= pcnt_ff + CntWidth'(1);
            pos_ff <= pos_ff + 24'd1;
            len_ff <= len_ff - 9'd1;
         end
         if (cmd.finish_chk && !full_early_ff && !fin_ff) begin
            if (pos_ff >= output_size) begin
               fin_ff <= 1'b1; stat_ff <= ST_FULL;
            end else if (last_ff) begin
               fin_ff <= 1'b1; stat_ff <= ST_TRUNC;
            end
         end
         if (cmd.emit || cmd.emit_empty) begin
            ov_ff <= 1'b1;
            pcnt_ff <= '0;
         end else if (ov_ff && rsp_ready) ov_ff <= 1'b0;
      end
   end

   // the beat loaded after the final checks is the last one of the step
   always_ff @(posedge clock) begin
      if (reset) fin_stage_ff <= 1'b0;
      else if (cmd.finish_chk) fin_stage_ff <= 1'b1;
      else if (cmd.capture || cmd.emit || cmd.emit_empty) fin_stage_ff <= 1'b0;
   end
   assign emit_last = cmd.emit_empty || (cmd.emit && fin_stage_ff);

   always_comb begin
      data_pack = '0;
      for (int j = 0; j < BYTES_PER_RESULT; j++)
         if (CntWidth'(j) < pcnt_ff) data_pack[8*j +: 8] = pack_ff[j];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit || cmd.emit_empty) begin
         od_ff <= cmd.emit ? data_pack : '0;
         oc_ff <= cmd.emit ? 4'(pcnt_ff) : 4'd0;
         ol_ff <= emit_last;
         os_ff <= emit_last ? stat_ff : ST_RUNNING;
         ob_ff <= pos_ff;
      end
   end

   assign sts.finished   = fin_ff;
   assign sts.can_bit    = loaded_ff && (flag_ff[30:0] != 31'd0);
   assign sts.bit_phase  = bit_ph && !full_early_ff;
   assign sts.copy_more  = len_ff != '0;
   assign sts.pack_full  = pcnt_ff == CntWidth'(BYTES_PER_RESULT);
   assign sts.pack_any   = pcnt_ff != '0;
   assign sts.status_set = stat_ff != ST_RUNNING;
   assign sts.out_busy   = ov_ff && !rsp_ready;

   assign rsp_valid      = ov_ff;
   assign rsp_out_data   = od_ff;
   assign rsp_out_count  = oc_ff;
   assign rsp_run_last   = ol_ff;
   assign rsp_status     = os_ff;
   assign rsp_bytes_done = ob_ff;
endmodule
`default_nettype wire

// ===== rtl/lzss_stream_decompressor.sv =====
// Top level of the LZSS stream decompressor: APB register, controller
// and datapath. Depends on lzss_pkg, lzss_if, lzss_ctrl, lzss_dpath.
//
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | in_byte, in_last
//  rsp     | out | valid/ready        | out_data, out_count, run_last, status, bytes_done
//  csr     | in  | APB psel/penable   | output_size at address 0
//
// A beat passes capture, a step per flag bit consumed, the byte step, a read and a
// write per copied byte, a hand-over per full pack inside a copy, the final checks
// and the emit; the history RAM read/write loop sets the copy rate. A beat after
// the run has ended is dropped in the idle state. A result still waiting holds the
// copy loop on a full pack and the last beat of a step. Synchronous reset; no clearing pass.
`default_nettype none
module lzss_stream_decompressor #(
   parameter int WINDOW_DEPTH = lzss_pkg::WindowDepthDefault,
   parameter int BYTES_PER_RESULT = lzss_pkg::BytesPerResultDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lzss_req_if.sink         req,
   lzss_rsp_if.source       rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import lzss_pkg::*;
   logic [23:0] size_ff;
   cmd_type cmd;
   sts_type sts;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) size_ff <= '0;
      else if (psel && penable && pwrite && paddr[2] == CSR_OUTPUT_SIZE)
         size_ff <= pwdata[23:0];
   end
   assign prdata = (paddr[2] == CSR_OUTPUT_SIZE) ? {8'd0, size_ff} : 32'd0;

   lzss_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .sts(sts), .cmd(cmd)
   );

   lzss_dpath #(.WINDOW_DEPTH(WINDOW_DEPTH), .BYTES_PER_RESULT(BYTES_PER_RESULT)) u_dp (
      .clock(clock), .reset(reset), .req_in_byte(req.in_byte), .req_in_last(req.in_last),
      .output_size(size_ff), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_out_data(rsp.out_data),
      .rsp_out_count(rsp.out_count), .rsp_run_last(rsp.run_last),
      .rsp_status(rsp.status), .rsp_bytes_done(rsp.bytes_done)
   );
endmodule
`default_nettype wire
